>>> hdl/sfcrc_pkg.sv
`default_nettype none
package sfcrc_pkg;

  localparam int unsigned BODY_LEN = 76;
  localparam logic [6:0] BODY_LEN_W = 7'(BODY_LEN);
  localparam logic [6:0] CHK_LO_POS = 7'(BODY_LEN + 1);

  localparam logic [7:0] SYNC_FIRST = 8'hDA;
  localparam logic [7:0] SYNC_SECOND = 8'h61;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_SYNC2  = 5'b00010,
    PH_BODY   = 5'b00100,
    PH_CHK_HI = 5'b01000,
    PH_CHK_LO = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_TAKEN   = 3'd1,
    ST_GOOD    = 3'd2,
    ST_HDR_BAD = 3'd3,
    ST_CHK_BAD = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [6:0]  byte_position;
    logic [7:0]  data_out;
    logic [31:0] error_total;
  } result_t;

  function automatic logic [15:0] crc16_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hdl/sync_framed_crc16_packet_parser_unit.sv
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_stall   rx_byte
// output   out        out_valid / out_stall status, byte_position, data_out, error_total
//
// One beat is taken per clock cycle while in_stall is low; its result is registered.
// The parse state and CRC update are done between the input and the result register.
// A skid register behind the result register takes one more beat while out_stall is high.
// in_stall is high only while the skid register holds a beat.
// rst is synchronous and returns the parser to hunting with an empty output.
`default_nettype none
module sync_framed_crc16_packet_parser_unit
  import sfcrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [6:0]       byte_position,
  output logic [7:0]       data_out,
  output logic [31:0]      error_total
);

  phase_t      phase, phase_next;
  logic [6:0]  byte_count, byte_count_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic [7:0]  check_high_byte, check_high_byte_next;
  logic [31:0] error_counter, error_counter_next;

  result_t     result_new;
  result_t     out_reg;
  result_t     skid_reg;
  logic        skid_valid;
  logic        accept;
  logic        take;
  logic [15:0] crc_step;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = out_valid && !out_stall;
  assign crc_step = crc16_add_byte((phase == PH_HUNT) ? CRC_INIT : crc_accum, rx_byte);

  always_comb begin
    status_t    st;
    logic [6:0] pos;
    phase_next           = phase;
    byte_count_next      = byte_count;
    crc_accum_next       = crc_accum;
    check_high_byte_next = check_high_byte;
    error_counter_next   = error_counter;
    st                   = ST_HUNT;
    pos                  = 7'd0;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == SYNC_FIRST) begin
          crc_accum_next  = crc_step;
          byte_count_next = 7'd1;
          phase_next      = PH_SYNC2;
          st              = ST_TAKEN;
        end
      end
      PH_SYNC2: begin
        if (rx_byte == SYNC_SECOND) begin
          crc_accum_next  = crc_step;
          pos             = byte_count;
          byte_count_next = 7'd2;
          st              = ST_TAKEN;
          phase_next      = (7'd2 >= BODY_LEN_W) ? PH_CHK_HI : PH_BODY;
        end else begin
          error_counter_next = error_counter + 32'd1;
          st                 = ST_HDR_BAD;
          phase_next         = PH_HUNT;
          byte_count_next    = 7'd0;
          crc_accum_next     = CRC_INIT;
        end
      end
      PH_BODY: begin
        crc_accum_next  = crc_step;
        pos             = byte_count;
        byte_count_next = byte_count + 7'd1;
        st              = ST_TAKEN;
        if (byte_count_next >= BODY_LEN_W) begin
          phase_next = PH_CHK_HI;
        end
      end
      PH_CHK_HI: begin
        check_high_byte_next = rx_byte;
        pos                  = BODY_LEN_W;
        st                   = ST_TAKEN;
        phase_next           = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        if (crc_accum == {check_high_byte, rx_byte}) begin
          st  = ST_GOOD;
          pos = CHK_LO_POS;
        end else begin
          error_counter_next = error_counter + 32'd1;
          st                 = ST_CHK_BAD;
        end
        phase_next      = PH_HUNT;
        byte_count_next = 7'd0;
        crc_accum_next  = CRC_INIT;
      end
      default: begin
        phase_next      = PH_HUNT;
        byte_count_next = 7'd0;
        crc_accum_next  = CRC_INIT;
      end
    endcase
    result_new.status        = st;
    result_new.byte_position = pos;
    result_new.data_out      = rx_byte;
    result_new.error_total   = error_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      byte_count      <= 7'd0;
      crc_accum       <= CRC_INIT;
      check_high_byte <= 8'd0;
      error_counter   <= 32'd0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      crc_accum       <= crc_accum_next;
      check_high_byte <= check_high_byte_next;
      error_counter   <= error_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || take) begin
        out_reg   <= result_new;
        out_valid <= 1'b1;
      end else begin
        skid_reg   <= result_new;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  assign status        = out_reg.status;
  assign byte_position = out_reg.byte_position;
  assign data_out      = out_reg.data_out;
  assign error_total   = out_reg.error_total;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid register holds a beat while the output register is empty.");

  a_accept_gives_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("An accepted beat did not produce a result.");

  a_error_step: assert property (@(posedge clk) disable iff (rst)
    (accept && (result_new.status == ST_HDR_BAD || result_new.status == ST_CHK_BAD))
    |=> error_counter == $past(error_counter) + 32'd1)
    else $error("Error count did not advance by one on a failure.");

  a_error_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(error_counter))
    else $error("Error count changed without an accepted beat.");

  a_body_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> (byte_count >= 7'd2 && byte_count < BODY_LEN_W))
    else $error("Body byte count out of range.");

endmodule
`default_nettype wire

>>> dv/sync_framed_crc16_packet_parser_unit_tb.sv
`timescale 1ns / 100ps
module sync_framed_crc16_packet_parser_unit_tb;
  import sfcrc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [6:0]  byte_position;
  logic [7:0]  data_out;
  logic [31:0] error_total;

  sync_framed_crc16_packet_parser_unit i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .byte_position(byte_position),
    .data_out(data_out),
    .error_total(error_total)
  );

  always #2 clk = ~clk;

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  typedef struct {
    logic [7:0]  b;
    bit          typed;
    status_t     st;
    logic [6:0]  pos;
    logic [31:0] errs;
  } plan_row_t;

  localparam int N_ROWS = 13;
  localparam int ITEMS_PER_PHASE = 375;

  plan_row_t opening_plan [N_ROWS] = '{
    '{8'h00, 1'b1, ST_HUNT,    7'd0, 32'd0},
    '{8'hFF, 1'b1, ST_HUNT,    7'd0, 32'd0},
    '{8'h61, 1'b1, ST_HUNT,    7'd0, 32'd0},
    '{8'hDA, 1'b1, ST_TAKEN,   7'd0, 32'd0},
    '{8'h00, 1'b1, ST_HDR_BAD, 7'd0, 32'd1},
    '{8'hDA, 1'b1, ST_TAKEN,   7'd0, 32'd1},
    '{8'hDA, 1'b1, ST_HDR_BAD, 7'd0, 32'd2},
    '{8'h61, 1'b1, ST_HUNT,    7'd0, 32'd2},
    '{8'hDA, 1'b1, ST_TAKEN,   7'd0, 32'd2},
    '{8'h61, 1'b1, ST_TAKEN,   7'd1, 32'd2},
    '{8'h00, 1'b1, ST_TAKEN,   7'd2, 32'd2},
    '{8'hFF, 1'b1, ST_TAKEN,   7'd3, 32'd2},
    '{8'hA5, 1'b0, ST_HUNT,    7'd0, 32'd0}
  };

  phase_t      frame_phase;
  logic [6:0]  body_count;
  logic [15:0] body_crc;
  logic [7:0]  check_hi;
  logic [31:0] fault_count;

  result_t parser_results_due[$];
  bit      row_typed = 1'b0;
  result_t row_result = '0;

  int mismatches = 0;
  int sent_count = 0;
  int in_pct = 0;
  int out_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void restart_hunt();
    frame_phase = PH_HUNT;
    body_count = 7'd0;
    body_crc = CRC_INIT;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    r.status = ST_HUNT;
    r.byte_position = 7'd0;
    r.data_out = b;
    case (frame_phase)
      PH_HUNT: begin
        if (b == SYNC_FIRST) begin
          body_crc = crc_next(CRC_INIT, b);
          body_count = 7'd1;
          frame_phase = PH_SYNC2;
          r.status = ST_TAKEN;
        end
      end
      PH_SYNC2: begin
        if (b == SYNC_SECOND) begin
          body_crc = crc_next(body_crc, b);
          r.byte_position = body_count;
          body_count = 7'd2;
          r.status = ST_TAKEN;
          frame_phase = (body_count >= BODY_LEN_W) ? PH_CHK_HI : PH_BODY;
        end else begin
          fault_count = fault_count + 32'd1;
          r.status = ST_HDR_BAD;
          restart_hunt();
        end
      end
      PH_BODY: begin
        body_crc = crc_next(body_crc, b);
        r.byte_position = body_count;
        body_count = body_count + 7'd1;
        r.status = ST_TAKEN;
        if (body_count >= BODY_LEN_W) begin
          frame_phase = PH_CHK_HI;
        end
      end
      PH_CHK_HI: begin
        check_hi = b;
        r.byte_position = BODY_LEN_W;
        r.status = ST_TAKEN;
        frame_phase = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        if (body_crc == {check_hi, b}) begin
          r.status = ST_GOOD;
          r.byte_position = CHK_LO_POS;
        end else begin
          fault_count = fault_count + 32'd1;
          r.status = ST_CHK_BAD;
        end
        restart_hunt();
      end
      default: begin
        restart_hunt();
      end
    endcase
    r.error_total = fault_count;
    return r;
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) begin
      return 0;
    end
    if ($urandom_range(9) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      n;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parser_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected beat status %0d pos %0d data %02h errors %0d", $time,
                     status, byte_position, data_out, error_total);
          end
        end else begin
          want = parser_results_due.pop_front();
          if (status !== want.status || byte_position !== want.byte_position ||
              data_out !== want.data_out || error_total !== want.error_total) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: expected status %0d pos %0d data %02h errors %0d, got %0d %0d %02h %0d",
                       $time, want.status, want.byte_position, want.data_out, want.error_total,
                       status, byte_position, data_out, error_total);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = parse_byte(rx_byte);
        parser_results_due.push_back(row_typed ? row_result : want);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        n = pick_gap(out_pct);
        stall_left = (n > 0) ? n - 1 : 0;
        out_stall <= (n > 0);
      end
    end
  end

  task automatic offer(input logic [7:0] b, input bit typed, input result_t res);
    int gap;
    in_valid <= 1'b1;
    rx_byte <= b;
    row_typed <= typed;
    row_result <= res;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent_count++;
    gap = pick_gap(in_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (parser_results_due.size() != 0);
  endtask

  initial begin
    result_t     res;
    int          pick;
    logic [7:0]  b;
    logic [15:0] crc;
    logic [15:0] word;
    fault_count = 32'd0;
    check_hi = 8'd0;
    restart_hunt();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_plan[i]) begin
      res.status = opening_plan[i].st;
      res.byte_position = opening_plan[i].pos;
      res.data_out = opening_plan[i].b;
      res.error_total = opening_plan[i].errs;
      offer(opening_plan[i].b, opening_plan[i].typed, res);
    end

    for (int p = 0; p < 4; p++) begin
      in_pct = (p == 1) ? 25 : (p == 3) ? 50 : (p == 2) ? 0 : 0;
      out_pct = (p == 1) ? 25 : (p == 2) ? 50 : (p == 3) ? 10 : 0;
      if (p == 2) begin
        hold_req = 1'b1;
      end
      while (sent_count < N_ROWS + (p + 1) * ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          crc = CRC_INIT;
          for (int i = 0; i < BODY_LEN; i++) begin
            b = (i == 0) ? SYNC_FIRST : (i == 1) ? SYNC_SECOND : 8'($urandom);
            crc = crc_next(crc, b);
            offer(b, 1'b0, '0);
          end
          word = ($urandom_range(3) != 0) ? crc : crc ^ (16'd1 << $urandom_range(15));
          offer(word[15:8], 1'b0, '0);
          offer(word[7:0], 1'b0, '0);
        end else if (pick < 85) begin
          offer(SYNC_FIRST, 1'b0, '0);
          b = 8'($urandom);
          if (b == SYNC_SECOND) begin
            b = ~b;
          end
          offer(b, 1'b0, '0);
        end else begin
          repeat ($urandom_range(1, 8)) begin
            b = ($urandom_range(3) == 0) ? SYNC_SECOND : 8'($urandom);
            offer(b, 1'b0, '0);
          end
        end
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && parser_results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
